>>> rtl/sha256c_pkg.sv
// ----------------------------------------------------------------------------
// sha256c_pkg
// Shared types, constants and round functions of the SHA-256 compression block.
// ----------------------------------------------------------------------------
package sha256c_pkg;

    localparam int WORD_W          = 32;
    localparam int BLOCK_WORDS     = 16;
    localparam int ROUNDS          = 64;
    localparam int HASH_WORDS      = 8;
    localparam int BLK_QUEUE_DEPTH = 2;
    localparam int WIDX_W          = $clog2(BLOCK_WORDS);
    localparam int RND_W           = $clog2(ROUNDS);
    localparam int HIDX_W          = $clog2(HASH_WORDS);

    localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [WORD_W-1:0] HASH_IV [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic [WORD_W-1:0] msg_word;
        logic              first_block;
        logic              final_block;
    } msg_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] digest_word;
        logic [HIDX_W-1:0] word_index;
        logic              last;
    } digest_item_t;

    // one word write into the block queue
    typedef struct packed {
        logic              valid;
        logic              commit;
        logic [WIDX_W-1:0] word_idx;
        logic [WORD_W-1:0] data;
        logic              first_block;
        logic              final_block;
    } wr_req_t;

    typedef struct packed {
        logic [BLOCK_WORDS-1:0][WORD_W-1:0] words;
        logic                               first_block;
        logic                               final_block;
    } block_t;

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [WORD_W-1:0] choose(input logic [WORD_W-1:0] x,
                                                 input logic [WORD_W-1:0] y,
                                                 input logic [WORD_W-1:0] z);
        return (x & y) ^ (~x & z);
    endfunction

    function automatic logic [WORD_W-1:0] majority(input logic [WORD_W-1:0] x,
                                                   input logic [WORD_W-1:0] y,
                                                   input logic [WORD_W-1:0] z);
        return (x & y) ^ (x & z) ^ (y & z);
    endfunction

endpackage

>>> rtl/sha256_block_compression.sv
// ----------------------------------------------------------------------------
// sha256_block_compression
// SHA-256 compression of padded message blocks, one 32-bit word per item.
// ----------------------------------------------------------------------------
// message words are taken one per cycle while the block queue has a free slot
// the round engine handles each block after its sixteenth word in order:
// one load, 64 rounds at one round per cycle, one chaining add
// a final block then gives its eight digest items after the add, one per cycle
// while digest_ready is high; throughput is set by the single round unit
// reset: chaining value back to the initial hash, word count zero, queue empty
module sha256_block_compression
    import sha256c_pkg::*;
#(
    parameter int QUEUE_DEPTH = BLK_QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         msg_valid,
    output logic         msg_ready,
    input  msg_item_t    msg,
    output logic         digest_valid,
    input  logic         digest_ready,
    output digest_item_t digest
);

    wr_req_t wr;
    logic    q_full;
    logic    blk_valid;
    logic    blk_pop;
    block_t  blk;

    sha256c_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_ready (msg_ready),
        .msg       (msg),
        .q_full    (q_full),
        .wr        (wr)
    );

    sha256c_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .full      (q_full),
        .blk_valid (blk_valid),
        .blk_pop   (blk_pop),
        .blk       (blk)
    );

    sha256c_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .blk_valid    (blk_valid),
        .blk_pop      (blk_pop),
        .blk          (blk),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest       (digest)
    );

endmodule

>>> rtl/sha256c_front.sv
// ----------------------------------------------------------------------------
// sha256c_front
// Counts incoming message words and places each at its slot in the block queue.
// ----------------------------------------------------------------------------
module sha256c_front
    import sha256c_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      msg_valid,
    output logic      msg_ready,
    input  msg_item_t msg,
    input  logic      q_full,
    output wr_req_t   wr
);

    logic [WIDX_W-1:0] word_count_reg;
    logic [WIDX_W-1:0] word_count_next;
    logic              accept;

    assign msg_ready = !q_full;
    assign accept    = msg_valid && !q_full;

    always_comb
    begin
        wr.valid       = accept;
        wr.commit      = accept && (word_count_reg == WIDX_W'(BLOCK_WORDS - 1));
        wr.word_idx    = word_count_reg;
        wr.data        = msg.msg_word;
        wr.first_block = msg.first_block;
        wr.final_block = msg.final_block;
        // wraps to zero after the sixteenth word
        word_count_next = accept ? word_count_reg + 1'b1 : word_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_count_reg <= '0;
        end
        else
        begin
            word_count_reg <= word_count_next;
        end
    end

endmodule

>>> rtl/sha256c_queue.sv
// ----------------------------------------------------------------------------
// sha256c_queue
// Small queue of whole message blocks, filled a word at a time, read a block at a time.
// ----------------------------------------------------------------------------
module sha256c_queue
    import sha256c_pkg::*;
#(
    parameter int DEPTH = BLK_QUEUE_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  wr_req_t wr,
    output logic    full,
    output logic    blk_valid,
    input  logic    blk_pop,
    output block_t  blk
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [BLOCK_WORDS-1:0][WORD_W-1:0] words_mem [DEPTH];
    logic                               first_mem [DEPTH];
    logic                               final_mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign blk_valid = (count_reg != '0);

    always_comb
    begin
        blk.words       = words_mem[rd_ptr_reg];
        blk.first_block = first_mem[rd_ptr_reg];
        blk.final_block = final_mem[rd_ptr_reg];
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr.commit)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (blk_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr.commit && !blk_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (blk_pop && !wr.commit)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // the slot under the write pointer is not visible to the reader until committed
    always_ff @(posedge clk)
    begin
        if (wr.valid)
        begin
            words_mem[wr_ptr_reg][wr.word_idx] <= wr.data;
        end
        if (wr.commit)
        begin
            first_mem[wr_ptr_reg] <= wr.first_block;
            final_mem[wr_ptr_reg] <= wr.final_block;
        end
    end

`ifndef ASSERT_OFF
    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr.valid && full))
        else $error("word written into a full block queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("block queue count out of range");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        blk_pop |-> blk_valid)
        else $error("block popped from an empty queue");
`endif

endmodule

>>> rtl/sha256c_core.sv
// ----------------------------------------------------------------------------
// sha256c_core
// Round engine: one SHA-256 round per cycle, rolling schedule, digest output.
// ----------------------------------------------------------------------------
module sha256c_core
    import sha256c_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         blk_valid,
    output logic         blk_pop,
    input  block_t       blk,
    output logic         digest_valid,
    input  logic         digest_ready,
    output digest_item_t digest
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_ADD   = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]                         state_reg, state_next;
    logic [RND_W-1:0]                   round_reg, round_next;
    logic [HIDX_W-1:0]                  idx_reg, idx_next;
    logic                               final_reg, final_next;
    logic [HASH_WORDS-1:0][WORD_W-1:0]  cv_reg, cv_next;
    logic [HASH_WORDS-1:0][WORD_W-1:0]  wv_reg, wv_next;
    logic [BLOCK_WORDS-1:0][WORD_W-1:0] win_reg, win_next;

    logic [WORD_W-1:0] t1;
    logic [WORD_W-1:0] t2;
    logic [WORD_W-1:0] sched_new;

    assign blk_pop      = (state_reg == ST_IDLE) && blk_valid;
    assign digest_valid = (state_reg == ST_EMIT);

    always_comb
    begin
        digest.digest_word = cv_reg[idx_reg];
        digest.word_index  = idx_reg;
        digest.last        = (idx_reg == HIDX_W'(HASH_WORDS - 1));
    end

    // wv_reg[0..7] hold a..h; win_reg[0] is the schedule word of this round
    always_comb
    begin
        t1 = wv_reg[7] + big_sigma1(wv_reg[4]) + choose(wv_reg[4], wv_reg[5], wv_reg[6])
           + ROUND_K[round_reg] + win_reg[0];
        t2 = big_sigma0(wv_reg[0]) + majority(wv_reg[0], wv_reg[1], wv_reg[2]);
        sched_new = small_sigma1(win_reg[14]) + win_reg[9]
                  + small_sigma0(win_reg[1]) + win_reg[0];
    end

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        idx_next   = idx_reg;
        final_next = final_reg;
        cv_next    = cv_reg;
        wv_next    = wv_reg;
        win_next   = win_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (blk_valid)
                begin
                    win_next   = blk.words;
                    final_next = blk.final_block;
                    round_next = '0;
                    state_next = ST_ROUND;
                    for (int i = 0; i < HASH_WORDS; i++)
                    begin
                        if (blk.first_block)
                        begin
                            cv_next[i] = HASH_IV[i];
                            wv_next[i] = HASH_IV[i];
                        end
                        else
                        begin
                            wv_next[i] = cv_reg[i];
                        end
                    end
                end
            end
            ST_ROUND:
            begin
                for (int i = 0; i < BLOCK_WORDS - 1; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[BLOCK_WORDS-1] = sched_new;
                wv_next[7] = wv_reg[6];
                wv_next[6] = wv_reg[5];
                wv_next[5] = wv_reg[4];
                wv_next[4] = wv_reg[3] + t1;
                wv_next[3] = wv_reg[2];
                wv_next[2] = wv_reg[1];
                wv_next[1] = wv_reg[0];
                wv_next[0] = t1 + t2;
                // wraps back to zero after the last round
                round_next = round_reg + 1'b1;
                if (round_reg == RND_W'(ROUNDS - 1))
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                for (int i = 0; i < HASH_WORDS; i++)
                begin
                    cv_next[i] = cv_reg[i] + wv_reg[i];
                end
                idx_next   = '0;
                state_next = final_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (digest_ready)
                begin
                    if (idx_reg == HIDX_W'(HASH_WORDS - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
            idx_reg   <= '0;
            final_reg <= 1'b0;
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                cv_reg[i] <= HASH_IV[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
            final_reg <= final_next;
            cv_reg    <= cv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wv_reg  <= wv_next;
        win_reg <= win_next;
    end

`ifndef ASSERT_OFF
    a_round_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_ROUND) |-> (round_reg == '0))
        else $error("round counter not back at zero outside the rounds");

    a_last_round_add: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && round_reg == RND_W'(ROUNDS - 1)) |=> (state_reg == ST_ADD))
        else $error("compression did not end after the last round");

    a_last_word_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && digest_ready && digest.last) |=> (state_reg == ST_IDLE))
        else $error("engine did not return to idle after the last digest item");
`endif

endmodule
